// ===== rtl/acct_pkg.sv =====
// Shared types, constants and saturation helpers for the cursor tracker.
`timescale 1ns / 1ps

package acct_pkg;

    // Screen and parser limits
    localparam int SCREEN_WIDTH    = 800;
    localparam int SCREEN_HEIGHT   = 600;
    localparam int MAX_ARGS        = 16;
    localparam int MAX_PARAM_BYTES = 63;
    localparam int ARG_LIMIT       = 9999;
    localparam int TAB_CELLS       = 8;

    localparam int ARG_W   = 14;
    localparam int TOTAL_W = 5;
    localparam int COUNT_W = 6;
    localparam int MULA_W  = 18;
    localparam int PROD_W  = MULA_W + 9;
    localparam int SUM_W   = PROD_W + 1;
    localparam int DIV_W   = 16;
    localparam int DCNT_W  = 4;

    localparam logic [TOTAL_W-1:0] MAX_ARGS_V   = TOTAL_W'(MAX_ARGS);
    localparam logic [COUNT_W-1:0] MAX_PBYTES_V = COUNT_W'(MAX_PARAM_BYTES);
    localparam logic [ARG_W-1:0]   ARG_LIMIT_V  = ARG_W'(ARG_LIMIT);
    localparam logic [DCNT_W-1:0]  DIV_LAST_V   = DCNT_W'(DIV_W - 1);

    localparam logic signed [SUM_W-1:0] SCREEN_W_S = SUM_W'(SCREEN_WIDTH);
    localparam logic signed [SUM_W-1:0] SCREEN_H_S = SUM_W'(SCREEN_HEIGHT);
    localparam logic [15:0] SCREEN_W_16 = 16'(SCREEN_WIDTH);
    localparam logic [15:0] SCREEN_H_16 = 16'(SCREEN_HEIGHT);
    localparam logic signed [SUM_W-1:0] X_MIN_S = -(SUM_W'(32768));
    localparam logic signed [SUM_W-1:0] X_MAX_S = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] Y_MAX_S = SUM_W'(65535);
    localparam logic signed [MULA_W-1:0] TAB_CELLS_S = MULA_W'(TAB_CELLS);

    // Configuration register indexes
    localparam logic CFG_CELL_WIDTH  = 1'b0;
    localparam logic CFG_CELL_HEIGHT = 1'b1;
    localparam logic [7:0] CELL_WIDTH_RST  = 8'd8;
    localparam logic [7:0] CELL_HEIGHT_RST = 8'd16;

    // Result commands
    localparam logic [1:0] CMD_CURSOR = 2'd0;
    localparam logic [1:0] CMD_GLYPH  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Byte codes
    localparam logic [7:0] CH_BEL      = 8'h07;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] FINAL_LO    = 8'h40;
    localparam logic [7:0] FINAL_HI    = 8'h7E;
    localparam logic [7:0] FIN_UP      = 8'h41;
    localparam logic [7:0] FIN_DOWN    = 8'h42;
    localparam logic [7:0] FIN_RIGHT   = 8'h43;
    localparam logic [7:0] FIN_LEFT    = 8'h44;
    localparam logic [7:0] FIN_CUP     = 8'h48;
    localparam logic [7:0] FIN_HVP     = 8'h66;
    localparam logic [7:0] FIN_SAVE    = 8'h73;
    localparam logic [7:0] FIN_RESTORE = 8'h75;

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_CSI
    } t_mode;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_GLYPH,
        OP_BS,
        OP_NL,
        OP_CR,
        OP_TAB,
        OP_CUP,
        OP_UP,
        OP_DOWN,
        OP_RIGHT,
        OP_LEFT,
        OP_SAVE,
        OP_RESTORE
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DISPATCH,
        S_DIV_X,
        S_SAVE_X,
        S_DIV_Y,
        S_SAVE_Y,
        S_MUL_Y,
        S_APPLY_Y,
        S_MUL_X,
        S_APPLY_X,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic decode;
        logic div_start_x;
        logic div_start_y;
        logic div_step;
        logic save_col;
        logic save_row;
        logic mul_x;
        logic mul_y;
        logic apply_x;
        logic apply_y;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic div_last;
    } t_sts;

    function automatic logic [15:0] sat_x(input logic signed [SUM_W-1:0] v);
        logic [15:0] r;
        if (v < X_MIN_S) begin
            r = 16'h8000;
        end else if (v > X_MAX_S) begin
            r = 16'h7FFF;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] sat_y(input logic signed [SUM_W-1:0] v);
        logic [15:0] r;
        if (v < 0) begin
            r = 16'h0000;
        end else if (v > Y_MAX_S) begin
            r = 16'hFFFF;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/acct_ctrl.sv =====
// Sequencer: decode per byte, then divide, multiply and apply as needed.
`timescale 1ns / 1ps

module acct_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  acct_pkg::t_sts i_sts,
    output acct_pkg::t_cmd o_cmd
);
    import acct_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: n_state = S_DISPATCH;
            S_DISPATCH: begin
                case (i_sts.op)
                    OP_TAB, OP_SAVE:                   n_state = S_DIV_X;
                    OP_CUP, OP_RESTORE, OP_UP, OP_DOWN: n_state = S_MUL_Y;
                    OP_RIGHT, OP_LEFT:                 n_state = S_MUL_X;
                    default:                           n_state = S_DONE;
                endcase
            end
            S_DIV_X: begin
                if (i_sts.div_last) n_state = (i_sts.op == OP_SAVE) ? S_SAVE_X : S_MUL_X;
            end
            S_SAVE_X: n_state = S_DIV_Y;
            S_DIV_Y: begin
                if (i_sts.div_last) n_state = S_SAVE_Y;
            end
            S_SAVE_Y: n_state = S_DONE;
            S_MUL_Y:  n_state = S_APPLY_Y;
            S_APPLY_Y: begin
                if (i_sts.op == OP_CUP || i_sts.op == OP_RESTORE) begin
                    n_state = S_MUL_X;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL_X:   n_state = S_APPLY_X;
            S_APPLY_X: n_state = S_DONE;
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_DECODE: o_cmd.decode = 1'b1;
            S_DISPATCH: begin
                o_cmd.div_start_x = (i_sts.op == OP_TAB) || (i_sts.op == OP_SAVE);
            end
            S_DIV_X, S_DIV_Y: o_cmd.div_step = 1'b1;
            S_SAVE_X: begin
                o_cmd.save_col    = 1'b1;
                o_cmd.div_start_y = 1'b1;
            end
            S_SAVE_Y:  o_cmd.save_row = 1'b1;
            S_MUL_Y:   o_cmd.mul_y    = 1'b1;
            S_APPLY_Y: o_cmd.apply_y  = 1'b1;
            S_MUL_X:   o_cmd.mul_x    = 1'b1;
            S_APPLY_X: o_cmd.apply_x  = 1'b1;
            S_DONE:    o_cmd.load_out = out_free;
            default: ;
        endcase
    end

    assign n_out_valid = o_cmd.load_out || (r_out_valid && !i_out_ready);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/acct_dp.sv =====
// Parser state, cursor registers, shared multiplier, serial divider and result word.
`timescale 1ns / 1ps

module acct_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  acct_pkg::t_cmd     i_cmd,
    output acct_pkg::t_sts     o_sts,
    input  logic [7:0]         i_byte_in,
    input  logic [7:0]         i_cell_w,
    input  logic [7:0]         i_cell_h,
    output logic [1:0]         o_command,
    output logic [7:0]         o_glyph_code,
    output logic signed [15:0] o_cell_x,
    output logic [15:0]        o_cell_y,
    output logic signed [15:0] o_cursor_x,
    output logic [15:0]        o_cursor_y
);
    import acct_pkg::*;

    // Architectural state
    t_mode               r_mode;
    logic [COUNT_W-1:0]  r_pcount;
    logic [ARG_W-1:0]    r_arg0;
    logic [ARG_W-1:0]    r_arg1;
    logic [TOTAL_W-1:0]  r_total;
    logic [ARG_W-1:0]    r_seg;
    logic                r_seg_ne;
    logic [15:0]         r_pos_x;
    logic [15:0]         r_pos_y;
    logic [15:0]         r_saved_col;
    logic [15:0]         r_saved_row;
    t_op                 r_op;

    // Working registers
    logic [7:0]          r_byte;
    logic [1:0]          r_cmd;
    logic [7:0]          r_glyph;
    logic [15:0]         r_cx;
    logic [15:0]         r_cy;
    logic signed [PROD_W-1:0] r_prod;
    logic [DIV_W-1:0]    r_div_q;
    logic [7:0]          r_div_rem;
    logic [7:0]          r_div_d;
    logic                r_div_neg;
    logic [DCNT_W-1:0]   r_div_cnt;

    // Decode next values
    t_mode               n_mode;
    logic [COUNT_W-1:0]  n_pcount;
    logic [ARG_W-1:0]    n_arg0;
    logic [ARG_W-1:0]    n_arg1;
    logic [TOTAL_W-1:0]  n_total;
    logic [ARG_W-1:0]    n_seg;
    logic                n_seg_ne;
    t_op                 d_op;
    logic                do_close;
    logic [16:0]         digit_acc;

    logic signed [SUM_W-1:0] xs;
    logic signed [SUM_W-1:0] ys;
    logic signed [SUM_W-1:0] ws;
    logic signed [SUM_W-1:0] hs;
    logic signed [SUM_W-1:0] ps;
    logic [15:0]         x_plus_w;
    logic [15:0]         x_minus_w;
    logic [15:0]         y_plus_h;

    logic [ARG_W-1:0]    a0one;
    logic [ARG_W-1:0]    a1one;
    logic signed [DIV_W:0]    quot_s;
    logic signed [MULA_W-1:0] mul_a;
    logic [7:0]          mul_b;

    logic [8:0]          div_t;
    logic                div_ge;
    logic [7:0]          div_rem_n;

    logic signed [SUM_W-1:0] ty;
    logic signed [SUM_W-1:0] tx;
    logic [15:0]         apply_y_val;
    logic [15:0]         apply_x_val;

    // Parser: next mode, argument state and operation for the held byte
    always_comb begin
        n_mode    = r_mode;
        n_pcount  = r_pcount;
        n_arg0    = r_arg0;
        n_arg1    = r_arg1;
        n_total   = r_total;
        n_seg     = r_seg;
        n_seg_ne  = r_seg_ne;
        d_op      = OP_NONE;
        do_close  = 1'b0;
        digit_acc = {3'b0, r_seg} * 17'd10 + {13'b0, r_byte[3:0]};
        case (r_mode)
            MODE_ESC: begin
                if (r_byte == CH_LBRACKET) begin
                    n_mode   = MODE_CSI;
                    n_pcount = '0;
                    n_arg0   = '0;
                    n_arg1   = '0;
                    n_total  = '0;
                    n_seg    = '0;
                    n_seg_ne = 1'b0;
                end else begin
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_CSI: begin
                if (r_byte inside {[FINAL_LO:FINAL_HI]}) begin
                    do_close = 1'b1;
                    n_mode   = MODE_NORMAL;
                    case (r_byte)
                        FIN_CUP, FIN_HVP: d_op = OP_CUP;
                        FIN_UP:           d_op = OP_UP;
                        FIN_DOWN:         d_op = OP_DOWN;
                        FIN_RIGHT:        d_op = OP_RIGHT;
                        FIN_LEFT:         d_op = OP_LEFT;
                        FIN_SAVE:         d_op = OP_SAVE;
                        FIN_RESTORE:      d_op = OP_RESTORE;
                        default:          d_op = OP_NONE;
                    endcase
                end else if (r_pcount < MAX_PBYTES_V) begin
                    n_pcount = r_pcount + 1'b1;
                    if (r_byte == CH_SEMI) begin
                        do_close = 1'b1;
                    end else begin
                        n_seg_ne = 1'b1;
                        if (r_byte inside {[CH_ZERO:CH_NINE]}) begin
                            n_seg = (digit_acc > {3'b0, ARG_LIMIT_V}) ? ARG_LIMIT_V
                                                                       : digit_acc[ARG_W-1:0];
                        end
                    end
                end
            end
            default: begin
                case (r_byte)
                    CH_ESC:  n_mode = MODE_ESC;
                    CH_LF:   d_op = OP_NL;
                    CH_BS:   d_op = OP_BS;
                    CH_CR:   d_op = OP_CR;
                    CH_TAB:  d_op = OP_TAB;
                    CH_BEL:  d_op = OP_NONE;
                    default: d_op = OP_GLYPH;
                endcase
            end
        endcase
        // close the open segment; only the first two arguments are ever read
        if (do_close) begin
            if (r_seg_ne && r_total < MAX_ARGS_V) begin
                if (r_total == TOTAL_W'(0)) n_arg0 = r_seg;
                if (r_total == TOTAL_W'(1)) n_arg1 = r_seg;
                n_total = r_total + 1'b1;
            end
            n_seg    = '0;
            n_seg_ne = 1'b0;
        end
    end

    // Simple cursor arithmetic
    always_comb begin
        xs = SUM_W'($signed(r_pos_x));
        ys = $signed({{(SUM_W-16){1'b0}}, r_pos_y});
        ws = $signed({{(SUM_W-8){1'b0}}, i_cell_w});
        hs = $signed({{(SUM_W-8){1'b0}}, i_cell_h});
        ps = SUM_W'(r_prod);
        x_plus_w  = sat_x(xs + ws);
        x_minus_w = sat_x(xs - ws);
        y_plus_h  = sat_y(ys + hs);
    end

    // Multiplier operand selection
    always_comb begin
        a0one  = (r_total != '0 && r_arg0 != '0) ? r_arg0 : ARG_W'(1);
        a1one  = (r_total > TOTAL_W'(1) && r_arg1 != '0) ? r_arg1 : ARG_W'(1);
        quot_s = r_div_neg ? -$signed({1'b0, r_div_q}) : $signed({1'b0, r_div_q});
        mul_a  = $signed({{(MULA_W-ARG_W){1'b0}}, a0one});
        mul_b  = i_cell_h;
        if (i_cmd.mul_x) begin
            mul_b = i_cell_w;
            case (r_op)
                OP_CUP:     mul_a = $signed({{(MULA_W-ARG_W){1'b0}}, a1one - 1'b1});
                OP_RESTORE: mul_a = MULA_W'($signed(r_saved_col));
                OP_TAB:     mul_a = MULA_W'(quot_s) + TAB_CELLS_S;
                default:    mul_a = $signed({{(MULA_W-ARG_W){1'b0}}, a0one});
            endcase
        end else begin
            case (r_op)
                OP_CUP:     mul_a = $signed({{(MULA_W-ARG_W){1'b0}}, a0one - 1'b1});
                OP_RESTORE: mul_a = $signed({{(MULA_W-16){1'b0}}, r_saved_row});
                default:    mul_a = $signed({{(MULA_W-ARG_W){1'b0}}, a0one});
            endcase
        end
    end

    // One restoring divide step
    always_comb begin
        div_t     = {r_div_rem, r_div_q[DIV_W-1]};
        div_ge    = div_t >= {1'b0, r_div_d};
        div_rem_n = div_ge ? 8'(div_t - {1'b0, r_div_d}) : div_t[7:0];
    end

    // Apply the product to the cursor
    always_comb begin
        case (r_op)
            OP_UP:   ty = ys - ps;
            OP_DOWN: ty = ys + ps;
            default: ty = ps;
        endcase
        if (r_op == OP_DOWN && ty >= SCREEN_H_S) begin
            apply_y_val = SCREEN_H_16 - {8'b0, i_cell_h};
        end else begin
            apply_y_val = sat_y(ty);
        end
        case (r_op)
            OP_RIGHT: tx = xs + ps;
            OP_LEFT:  tx = xs - ps;
            default:  tx = ps;
        endcase
        if (r_op == OP_RIGHT && tx >= SCREEN_W_S) begin
            apply_x_val = SCREEN_W_16 - {8'b0, i_cell_w};
        end else if (r_op == OP_LEFT && tx < 0) begin
            apply_x_val = 16'h0000;
        end else begin
            apply_x_val = sat_x(tx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NORMAL;
            r_pcount    <= '0;
            r_arg0      <= '0;
            r_arg1      <= '0;
            r_total     <= '0;
            r_seg       <= '0;
            r_seg_ne    <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_saved_col <= '0;
            r_saved_row <= '0;
            r_op        <= OP_NONE;
        end else begin
            if (i_cmd.decode) begin
                r_mode   <= n_mode;
                r_pcount <= n_pcount;
                r_arg0   <= n_arg0;
                r_arg1   <= n_arg1;
                r_total  <= n_total;
                r_seg    <= n_seg;
                r_seg_ne <= n_seg_ne;
                r_op     <= d_op;
                case (d_op)
                    OP_GLYPH: r_pos_x <= x_plus_w;
                    OP_BS:    r_pos_x <= x_minus_w;
                    OP_NL: begin
                        r_pos_x <= '0;
                        r_pos_y <= y_plus_h;
                    end
                    OP_CR:    r_pos_x <= '0;
                    default: ;
                endcase
            end
            if (i_cmd.save_col) r_saved_col <= quot_s[15:0];
            if (i_cmd.save_row) r_saved_row <= r_div_q;
            if (i_cmd.apply_y)  r_pos_y     <= apply_y_val;
            if (i_cmd.apply_x)  r_pos_x     <= apply_x_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) r_byte <= i_byte_in;
        if (i_cmd.decode) begin
            r_cmd   <= CMD_CURSOR;
            r_glyph <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
            case (d_op)
                OP_GLYPH: begin
                    r_cmd   <= CMD_GLYPH;
                    r_glyph <= r_byte;
                    r_cx    <= r_pos_x;
                    r_cy    <= r_pos_y;
                end
                OP_BS: begin
                    r_cmd <= CMD_CLEAR;
                    r_cx  <= x_minus_w;
                    r_cy  <= r_pos_y;
                end
                default: ;
            endcase
        end
        if (i_cmd.mul_x || i_cmd.mul_y) begin
            r_prod <= mul_a * $signed({1'b0, mul_b});
        end
        if (i_cmd.div_start_x) begin
            r_div_q   <= r_pos_x[15] ? 16'(-r_pos_x) : r_pos_x;
            r_div_neg <= r_pos_x[15];
            r_div_d   <= i_cell_w;
            r_div_rem <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_start_y) begin
            r_div_q   <= r_pos_y;
            r_div_neg <= 1'b0;
            r_div_d   <= i_cell_h;
            r_div_rem <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_q   <= {r_div_q[DIV_W-2:0], div_ge};
            r_div_rem <= div_rem_n;
            r_div_cnt <= r_div_cnt + 1'b1;
        end
        if (i_cmd.load_out) begin
            o_command    <= r_cmd;
            o_glyph_code <= r_glyph;
            o_cell_x     <= r_cx;
            o_cell_y     <= r_cy;
            o_cursor_x   <= r_pos_x;
            o_cursor_y   <= r_pos_y;
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.div_last = (r_div_cnt == DIV_LAST_V);

endmodule

// ===== rtl/ansi_csi_cursor_tracker.sv =====
// Top level: cell size registers, sequencer and datapath of the cursor tracker.
`timescale 1ns / 1ps

// Terminal cursor tracker. Feed one output byte per word on the input channel
// (i_in_valid / o_in_ready, byte on i_byte_in); every byte yields exactly one
// result word on the output channel (o_out_valid / i_out_ready): a command
// (cursor only, draw glyph, clear cell), the glyph, the cell drawn or cleared
// and the cursor position after the byte, all in pixels.
// Cell size is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must
// do so while idle; the block does not enforce it. Zero size acts as one pixel.
// Plain bytes and controls pass decode and dispatch only; CSI A-D add multiply
// and apply, CSI H/f/u both for row and column; tab divides the column first
// and CSI s divides and saves column and row. Divides use the one-bit-per-cycle
// divider, multiplies the single shared 18x9 multiplier. One byte is in work
// at a time; the next byte is taken the cycle after its result is registered.
// The result sits in an output register, so a new byte is taken while the
// previous word waits; if the receiver still stalls when the next result is
// ready, the block holds in its final step until the register frees.
// Synchronous active-low reset returns to normal parse mode, cursor and saved
// position at 0, cell size 8 x 16, and no word pending.
module ansi_csi_cursor_tracker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_byte_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_command,
    output logic [7:0]         o_glyph_code,
    output logic signed [15:0] o_cell_x,
    output logic [15:0]        o_cell_y,
    output logic signed [15:0] o_cursor_x,
    output logic [15:0]        o_cursor_y,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [7:0]         i_cfg_data
);
    import acct_pkg::*;

    logic [7:0] r_cell_width;
    logic [7:0] r_cell_height;
    logic [7:0] cell_w_eff;
    logic [7:0] cell_h_eff;
    t_cmd       cmd;
    t_sts       sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_width  <= CELL_WIDTH_RST;
            r_cell_height <= CELL_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CELL_WIDTH:  r_cell_width  <= i_cfg_data;
                CFG_CELL_HEIGHT: r_cell_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero size behaves as one pixel
    assign cell_w_eff = (r_cell_width  == 8'd0) ? 8'd1 : r_cell_width;
    assign cell_h_eff = (r_cell_height == 8'd0) ? 8'd1 : r_cell_height;

    acct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    acct_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_byte_in    (i_byte_in),
        .i_cell_w     (cell_w_eff),
        .i_cell_h     (cell_h_eff),
        .o_command    (o_command),
        .o_glyph_code (o_glyph_code),
        .o_cell_x     (o_cell_x),
        .o_cell_y     (o_cell_y),
        .o_cursor_x   (o_cursor_x),
        .o_cursor_y   (o_cursor_y)
    );

endmodule
